FILE: design/gkc_pkg.sv
// ----------------------------------------------------------------------------
// gkc_pkg
// shared constants, fixed-point magic numbers and types for the gabor
// kernel coefficient generator
// ----------------------------------------------------------------------------
package gkc_pkg;

    // kernel radius limit and output fraction bits
    localparam int HALF_SIZE_MAX = 32;
    localparam int OUT_FRAC_BITS = 14;

    // pipeline latencies
    localparam int SC_LAT     = 17;              // sin/cos unit
    localparam int ENV_LAT    = 2 * SC_LAT + 2;  // envelope unit
    localparam int PIPE_DEPTH = 2 * SC_LAT + 5;  // input register to output register

    // fixed-point constants
    localparam logic [30:0] PI_HALF_Q30 = 31'd1686629713;
    localparam logic [29:0] INV_2PI_Q32 = 30'd683565276;
    localparam logic [29:0] LN2_Q30     = 30'd744261118;
    localparam logic [33:0] DC_Q30      = 34'd7722225;
    localparam logic [30:0] ONE_Q30     = 31'h4000_0000;

    // floor(2^46 / ln2_q30), never above the exact reciprocal
    localparam logic [16:0] LN2_RECIP = 17'((64'd1 << 46) / 64'd744261118);

    // exact division of a 32-bit value by a small constant:
    // q = (v * m) >> s with s = 32 + ceil(log2 d), m = floor(2^s / d) + 1
    typedef logic [32:0] magic_t;

    // sine series divisors 6 20 42 72 110 156 210
    localparam magic_t SIN_M [1:7] = '{
        33'((65'd1 << 35) / 65'd6   + 65'd1),
        33'((65'd1 << 37) / 65'd20  + 65'd1),
        33'((65'd1 << 38) / 65'd42  + 65'd1),
        33'((65'd1 << 39) / 65'd72  + 65'd1),
        33'((65'd1 << 39) / 65'd110 + 65'd1),
        33'((65'd1 << 40) / 65'd156 + 65'd1),
        33'((65'd1 << 40) / 65'd210 + 65'd1)
    };
    localparam int SIN_S [1:7] = '{35, 37, 38, 39, 39, 40, 40};

    // cosine series divisors 2 12 30 56 90 132 182
    localparam magic_t COS_M [1:7] = '{
        33'((65'd1 << 33) / 65'd2   + 65'd1),
        33'((65'd1 << 36) / 65'd12  + 65'd1),
        33'((65'd1 << 37) / 65'd30  + 65'd1),
        33'((65'd1 << 38) / 65'd56  + 65'd1),
        33'((65'd1 << 39) / 65'd90  + 65'd1),
        33'((65'd1 << 40) / 65'd132 + 65'd1),
        33'((65'd1 << 40) / 65'd182 + 65'd1)
    };
    localparam int COS_S [1:7] = '{33, 36, 37, 38, 39, 40, 40};

    // exponential series divisors 1 to 12
    localparam magic_t EXP_M [1:12] = '{
        33'((65'd1 << 32) / 65'd1  + 65'd1),
        33'((65'd1 << 33) / 65'd2  + 65'd1),
        33'((65'd1 << 34) / 65'd3  + 65'd1),
        33'((65'd1 << 34) / 65'd4  + 65'd1),
        33'((65'd1 << 35) / 65'd5  + 65'd1),
        33'((65'd1 << 35) / 65'd6  + 65'd1),
        33'((65'd1 << 35) / 65'd7  + 65'd1),
        33'((65'd1 << 35) / 65'd8  + 65'd1),
        33'((65'd1 << 36) / 65'd9  + 65'd1),
        33'((65'd1 << 36) / 65'd10 + 65'd1),
        33'((65'd1 << 36) / 65'd11 + 65'd1),
        33'((65'd1 << 36) / 65'd12 + 65'd1)
    };
    localparam int EXP_S [1:12] = '{32, 33, 34, 34, 35, 35, 35, 35, 36, 36, 36, 36};

    // signed q30 value with headroom
    typedef logic signed [33:0] q30_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_HALF_SIZE    = 2'd0,
        REG_SIGMA_WIDTH  = 2'd1,
        REG_ORIENTATION  = 2'd2,
        REG_SPATIAL_FREQ = 2'd3
    } cfg_reg_t;

endpackage

FILE: design/gabor_kernel_coefficient.sv
// ----------------------------------------------------------------------------
// gabor_kernel_coefficient
// real and imaginary gabor coefficients for one kernel position per transaction
//
// channel  | dir | handshake         | payload
// ---------+-----+-------------------+------------------------------------------
// s_       | in  | s_tvalid/s_tready | tdata: row_index, col_index
// m_       | out | m_tvalid/m_tready | tdata: real_part, imag_part; tuser: valid
// cfg_     | in  | cfg_we            | cfg_index, cfg_data (16 bits)
//
// one transaction in and one out per cycle unless the output stalls; the data
// passes two chained sin/cos pipelines with the envelope pipeline beside them
// all stages advance together; a stalled output freezes the whole pipeline
// rst_n clears valid bits and loads the configuration reset values
// ----------------------------------------------------------------------------
module gabor_kernel_coefficient #(
    parameter int HALF_SIZE_MAX = gkc_pkg::HALF_SIZE_MAX,
    parameter int OUT_FRAC_BITS = gkc_pkg::OUT_FRAC_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [5:0] row_index, [11:6] col_index, [15:12] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [15:0] real_part, [31:16] imag_part
    output logic        m_tuser,   // [0] position_valid
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import gkc_pkg::*;

    localparam int XY_TAP = SC_LAT + 1;       // stage where orientation sin/cos is ready
    localparam int SH     = 60 - OUT_FRAC_BITS;

    // configuration registers
    logic [5:0]  half_size_reg;
    logic [15:0] sigma_width_reg;
    logic [15:0] orientation_reg;
    logic [15:0] spatial_freq_reg;

    // pipeline control
    logic                  en;
    logic [PIPE_DEPTH:1]   vld_reg;
    logic [PIPE_DEPTH-1:1] inr_reg;

    // stage 1
    logic [5:0]         row;
    logic [5:0]         col;
    logic [5:0]         h;
    logic [6:0]         two_h;
    logic               in_range;
    logic signed [6:0]  x_next;
    logic signed [6:0]  y_next;
    logic signed [15:0] a13;
    logic [15:0]        amag;
    logic [45:0]        a_prod;
    logic [31:0]        pha_next;
    logic [31:0]        pha_reg;
    logic signed [6:0]  xd_reg [1:XY_TAP];
    logic signed [6:0]  yd_reg [1:XY_TAP];

    // projection and argument stages
    q30_t               sa;
    q30_t               ca;
    logic signed [40:0] d_next;
    logic signed [40:0] d_reg;
    logic [39:0]        dmag;
    logic [55:0]        f_prod;
    logic [31:0]        ph_next;
    logic [31:0]        ph_reg;

    // output stages
    q30_t        sarg;
    q30_t        carg;
    logic [30:0] env_val;
    q30_t        vi;
    logic [32:0] mag_re;
    logic [32:0] mag_im;
    logic [63:0] prod_re_reg;
    logic [63:0] prod_im_reg;
    logic        neg_re_reg;
    logic        neg_im_reg;
    logic [63:0] q_re;
    logic [63:0] q_im;
    logic [15:0] re_next;
    logic [15:0] im_next;
    logic [31:0] m_tdata_reg;
    logic        m_tuser_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_size_reg    <= 6'd8;
            sigma_width_reg  <= 16'd804;
            orientation_reg  <= 16'd0;
            spatial_freq_reg <= 16'd4096;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_HALF_SIZE:    half_size_reg    <= cfg_data[5:0];
                REG_SIGMA_WIDTH:  sigma_width_reg  <= cfg_data;
                REG_ORIENTATION:  orientation_reg  <= cfg_data;
                REG_SPATIAL_FREQ: spatial_freq_reg <= cfg_data;
            endcase
        end
    end

    // whole pipeline moves unless the output holds an untaken transaction
    assign en       = !vld_reg[PIPE_DEPTH] || m_tready;
    assign s_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[PIPE_DEPTH-1:1], s_tvalid};
        end
    end

    // stage 1: offsets, range check, orientation in turns
    always_comb
    begin
        row      = s_tdata[5:0];
        col      = s_tdata[11:6];
        h        = (int'(half_size_reg) > HALF_SIZE_MAX) ? 6'(HALF_SIZE_MAX) : half_size_reg;
        two_h    = {h, 1'b0};
        in_range = ({1'b0, row} < two_h) && ({1'b0, col} < two_h);
        y_next   = $signed({1'b0, row}) - $signed({1'b0, h});
        x_next   = $signed({1'b0, col}) - $signed({1'b0, h});
        a13      = $signed(orientation_reg);
        amag     = a13[15] ? 16'(-a13) : orientation_reg;
        a_prod   = {30'd0, amag} * {16'd0, INV_2PI_Q32};
        pha_next = a13[15] ? (32'd0 - a_prod[44:13]) : a_prod[44:13];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pha_reg   <= pha_next;
            xd_reg[1] <= x_next;
            yd_reg[1] <= y_next;
            for (int i = 2; i <= XY_TAP; i++)
            begin
                xd_reg[i] <= xd_reg[i-1];
                yd_reg[i] <= yd_reg[i-1];
            end
            inr_reg <= {inr_reg[PIPE_DEPTH-2:1], in_range};
        end
    end

    // orientation sin/cos
    gkc_sincos u_orient (
        .clk     (clk),
        .en      (en),
        .phase   (pha_reg),
        .sin_val (sa),
        .cos_val (ca)
    );

    // envelope runs beside both sin/cos units
    gkc_env u_env (
        .clk   (clk),
        .en    (en),
        .x     (xd_reg[1]),
        .y     (yd_reg[1]),
        .sigma (sigma_width_reg),
        .env   (env_val)
    );

    // projection d = y*cos a - x*sin a, then phase turns f*d
    always_comb
    begin
        d_next  = 41'(yd_reg[XY_TAP]) * 41'(ca) - 41'(xd_reg[XY_TAP]) * 41'(sa);
        dmag    = d_reg[40] ? 40'(-d_reg) : 40'(d_reg);
        f_prod  = {40'd0, spatial_freq_reg} * {16'd0, dmag};
        ph_next = d_reg[40] ? (32'd0 - f_prod[43:12]) : f_prod[43:12];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg  <= d_next;
            ph_reg <= ph_next;
        end
    end

    // argument sin/cos
    gkc_sincos u_arg (
        .clk     (clk),
        .en      (en),
        .phase   (ph_reg),
        .sin_val (sarg),
        .cos_val (carg)
    );

    // envelope times sine and times cosine less the dc term
    always_comb
    begin
        vi     = carg - q30_t'(DC_Q30);
        mag_re = sarg[33] ? 33'(-sarg) : 33'(sarg);
        mag_im = vi[33] ? 33'(-vi) : 33'(vi);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_re_reg <= {33'd0, env_val} * {31'd0, mag_re};
            prod_im_reg <= {33'd0, env_val} * {31'd0, mag_im};
            neg_re_reg  <= sarg[33];
            neg_im_reg  <= vi[33];
        end
    end

    // round half up on magnitude, restore sign, saturate
    always_comb
    begin
        q_re = (prod_re_reg + (64'd1 << (SH - 1))) >> SH;
        q_im = (prod_im_reg + (64'd1 << (SH - 1))) >> SH;
        if (neg_re_reg)
        begin
            re_next = (q_re > 64'd32768) ? 16'h8000 : 16'(64'd0 - q_re);
        end
        else
        begin
            re_next = (q_re > 64'd32767) ? 16'h7fff : q_re[15:0];
        end
        if (neg_im_reg)
        begin
            im_next = (q_im > 64'd32768) ? 16'h8000 : 16'(64'd0 - q_im);
        end
        else
        begin
            im_next = (q_im > 64'd32767) ? 16'h7fff : q_im[15:0];
        end
    end

    // output register; positions outside the kernel give zeros
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_tdata_reg <= inr_reg[PIPE_DEPTH-1] ? {im_next, re_next} : 32'd0;
            m_tuser_reg <= inr_reg[PIPE_DEPTH-1];
        end
    end

    assign m_tvalid = vld_reg[PIPE_DEPTH];
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef SYNTHESIS
    // outside the kernel both coefficients are zero
    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata == 32'd0))
        else $error("nonzero coefficient for position outside kernel");

    // an accepted transaction enters the first stage
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> vld_reg[1])
        else $error("accepted transaction missing from first stage");

    // a stall freezes every valid bit
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        (!en) |=> $stable(vld_reg))
        else $error("pipeline moved during stall");

    // input side only waits when output is stalled
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (!s_tready) |-> (m_tvalid && !m_tready))
        else $error("input refused without output stall");
`endif

endmodule

FILE: design/gkc_sincos.sv
// ----------------------------------------------------------------------------
// gkc_sincos
// pipelined sine and cosine of a phase in q32 turns, q30 results
// ----------------------------------------------------------------------------
module gkc_sincos (
    input  logic         clk,
    input  logic         en,
    input  logic [31:0]  phase,
    output gkc_pkg::q30_t sin_val,
    output gkc_pkg::q30_t cos_val
);
    import gkc_pkg::*;

    logic [60:0]  r_prod;
    logic [61:0]  r2_prod;
    logic [30:0]  r_reg;
    logic [1:0]   quad_reg [1:16];

    logic [31:0]  r2_reg  [0:7];
    logic [31:0]  ts_reg  [0:7];
    logic [31:0]  tc_reg  [0:7];
    q30_t         ss_reg  [0:7];
    q30_t         cs_reg  [0:7];

    logic [31:0]  r2a_reg [1:7];
    logic [31:0]  pts_reg [1:7];
    logic [31:0]  ptc_reg [1:7];
    q30_t         ssa_reg [1:7];
    q30_t         csa_reg [1:7];

    q30_t         sin_next;
    q30_t         cos_next;
    q30_t         sin_reg;
    q30_t         cos_reg;

    // quarter turn to radians, then r squared
    assign r_prod  = {31'd0, phase[29:0]} * {30'd0, PI_HALF_Q30};
    assign r2_prod = {31'd0, r_reg} * {31'd0, r_reg};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg       <= r_prod[60:30];
            quad_reg[1] <= phase[31:30];
            for (int i = 2; i <= 16; i++)
            begin
                quad_reg[i] <= quad_reg[i-1];
            end
            r2_reg[0] <= r2_prod[61:30];
            ts_reg[0] <= {1'b0, r_reg};
            tc_reg[0] <= {1'b0, ONE_Q30};
            ss_reg[0] <= q30_t'({3'b000, r_reg});
            cs_reg[0] <= q30_t'({3'b000, ONE_Q30});
        end
    end

    // one series term per two stages: multiply, then exact constant divide
    for (genvar gn = 1; gn <= 7; gn++)
    begin : g_term
        logic [63:0] ps_prod;
        logic [63:0] pc_prod;
        logic [64:0] qs_prod;
        logic [64:0] qc_prod;
        logic [31:0] ts_next;
        logic [31:0] tc_next;
        q30_t        ss_next;
        q30_t        cs_next;

        assign ps_prod = ts_reg[gn-1] * r2_reg[gn-1];
        assign pc_prod = tc_reg[gn-1] * r2_reg[gn-1];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pts_reg[gn] <= ps_prod[61:30];
                ptc_reg[gn] <= pc_prod[61:30];
                r2a_reg[gn] <= r2_reg[gn-1];
                ssa_reg[gn] <= ss_reg[gn-1];
                csa_reg[gn] <= cs_reg[gn-1];
            end
        end

        assign qs_prod = {33'd0, pts_reg[gn]} * {32'd0, SIN_M[gn]};
        assign qc_prod = {33'd0, ptc_reg[gn]} * {32'd0, COS_M[gn]};
        assign ts_next = 32'(qs_prod >> SIN_S[gn]);
        assign tc_next = 32'(qc_prod >> COS_S[gn]);

        // odd terms subtract, even terms add
        always_comb
        begin
            if ((gn % 2) != 0)
            begin
                ss_next = ssa_reg[gn] - q30_t'({2'b00, ts_next});
                cs_next = csa_reg[gn] - q30_t'({2'b00, tc_next});
            end
            else
            begin
                ss_next = ssa_reg[gn] + q30_t'({2'b00, ts_next});
                cs_next = csa_reg[gn] + q30_t'({2'b00, tc_next});
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ts_reg[gn] <= ts_next;
                tc_reg[gn] <= tc_next;
                ss_reg[gn] <= ss_next;
                cs_reg[gn] <= cs_next;
                r2_reg[gn] <= r2a_reg[gn];
            end
        end
    end

    // quadrant fold
    always_comb
    begin
        unique case (quad_reg[16])
            2'd0:
            begin
                sin_next = ss_reg[7];
                cos_next = cs_reg[7];
            end
            2'd1:
            begin
                sin_next = cs_reg[7];
                cos_next = -ss_reg[7];
            end
            2'd2:
            begin
                sin_next = -ss_reg[7];
                cos_next = -cs_reg[7];
            end
            default:
            begin
                sin_next = -cs_reg[7];
                cos_next = ss_reg[7];
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sin_reg <= sin_next;
            cos_reg <= cos_next;
        end
    end

    assign sin_val = sin_reg;
    assign cos_val = cos_reg;

endmodule

FILE: design/gkc_env.sv
// ----------------------------------------------------------------------------
// gkc_env
// pipelined gaussian envelope exp(-(x^2+y^2)/sigma) in q30
// ----------------------------------------------------------------------------
module gkc_env (
    input  logic              clk,
    input  logic              en,
    input  logic signed [6:0] x,
    input  logic signed [6:0] y,
    input  logic [15:0]       sigma,
    output logic [30:0]       env
);
    import gkc_pkg::*;

    logic signed [13:0] xx;
    logic signed [13:0] yy;
    logic [12:0]        r2;
    logic [15:0]        sig;

    logic               zd_reg   [0:34];
    logic [15:0]        drem_reg [0:7];
    logic [20:0]        dq_reg   [0:7];
    logic [15:0]        dsig_reg [0:7];

    logic [37:0]        k_prod;
    logic [20:0]        t16_reg;
    logic [5:0]         kest_reg;
    logic [35:0]        kl_prod;
    logic [35:0]        rraw;
    logic [30:0]        rraw_reg;
    logic [5:0]         kraw_reg;

    logic [30:0]        term_reg [0:12];
    logic signed [31:0] sum_reg  [0:12];
    logic [29:0]        erem_reg [0:12];
    logic [5:0]         ek_reg   [0:12];
    logic [30:0]        pt_reg   [1:12];
    logic signed [31:0] suma_reg [1:12];
    logic [29:0]        erema_reg[1:12];
    logic [5:0]         eka_reg  [1:12];

    logic [31:0]        env_shift;
    logic [30:0]        env_reg;

    // squared radius, zero sigma taken as one step
    assign xx  = x * x;
    assign yy  = y * y;
    assign r2  = 13'(xx) + 13'(yy);
    assign sig = (sigma == 16'd0) ? 16'd1 : sigma;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // quotient of 2^21 or more: envelope is zero
            zd_reg[0]   <= ({r2[12:0], 3'b000} >= sig);
            drem_reg[0] <= {r2[12:0], 3'b000};
            dq_reg[0]   <= '0;
            dsig_reg[0] <= sig;
            for (int i = 1; i <= 34; i++)
            begin
                zd_reg[i] <= zd_reg[i-1];
            end
        end
    end

    // restoring divide, three quotient bits per stage
    for (genvar gd = 1; gd <= 7; gd++)
    begin : g_div
        logic [15:0] rem_w;
        logic [16:0] sh_w;
        logic [20:0] q_w;

        always_comb
        begin
            rem_w = drem_reg[gd-1];
            q_w   = dq_reg[gd-1];
            sh_w  = '0;
            for (int i = 0; i < 3; i++)
            begin
                sh_w = {rem_w, 1'b0};
                if (sh_w >= {1'b0, dsig_reg[gd-1]})
                begin
                    sh_w = sh_w - {1'b0, dsig_reg[gd-1]};
                    q_w  = {q_w[19:0], 1'b1};
                end
                else
                begin
                    q_w  = {q_w[19:0], 1'b0};
                end
                rem_w = sh_w[15:0];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                drem_reg[gd] <= rem_w;
                dq_reg[gd]   <= q_w;
                dsig_reg[gd] <= dsig_reg[gd-1];
            end
        end
    end

    // split t into k*ln2 + rem: estimate k, then one correction
    assign k_prod  = {17'd0, dq_reg[7]} * {21'd0, LN2_RECIP};
    assign kl_prod = {30'd0, kest_reg} * {6'd0, LN2_Q30};
    assign rraw    = {1'b0, t16_reg, 14'd0} - kl_prod;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t16_reg  <= dq_reg[7];
            kest_reg <= k_prod[37:32];
            rraw_reg <= rraw[30:0];
            kraw_reg <= kest_reg;
            if (rraw_reg >= {1'b0, LN2_Q30})
            begin
                erem_reg[0] <= 30'(rraw_reg - {1'b0, LN2_Q30});
                ek_reg[0]   <= kraw_reg + 6'd1;
            end
            else
            begin
                erem_reg[0] <= rraw_reg[29:0];
                ek_reg[0]   <= kraw_reg;
            end
            term_reg[0] <= ONE_Q30;
            sum_reg[0]  <= 32'({1'b0, ONE_Q30});
        end
    end

    // exp(-rem) series, two stages per term
    for (genvar gn = 1; gn <= 12; gn++)
    begin : g_exp
        logic [60:0]        p_prod;
        logic [64:0]        q_prod;
        logic [30:0]        term_next;
        logic signed [31:0] sum_next;

        assign p_prod = {30'd0, term_reg[gn-1]} * {31'd0, erem_reg[gn-1]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pt_reg[gn]    <= p_prod[60:30];
                suma_reg[gn]  <= sum_reg[gn-1];
                erema_reg[gn] <= erem_reg[gn-1];
                eka_reg[gn]   <= ek_reg[gn-1];
            end
        end

        assign q_prod    = {34'd0, pt_reg[gn]} * {32'd0, EXP_M[gn]};
        assign term_next = 31'(q_prod >> EXP_S[gn]);

        always_comb
        begin
            if ((gn % 2) != 0)
            begin
                sum_next = suma_reg[gn] - 32'({1'b0, term_next});
            end
            else
            begin
                sum_next = suma_reg[gn] + 32'({1'b0, term_next});
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                term_reg[gn] <= term_next;
                sum_reg[gn]  <= sum_next;
                erem_reg[gn] <= erema_reg[gn];
                ek_reg[gn]   <= eka_reg[gn];
            end
        end
    end

    assign env_shift = $unsigned(sum_reg[12]) >> ek_reg[12];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            env_reg <= zd_reg[34] ? 31'd0 : env_shift[30:0];
        end
    end

    assign env = env_reg;

endmodule
